// ===== rtl/dlf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_pkg
// Shared types, constants and pixel arithmetic for the deinterlace line filter.
// ----------------------------------------------------------------------------
package dlf_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = 13;
  localparam int CMP_W      = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 32;
  localparam int MODE_W     = 3;

  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = DIM_W'(720);
  localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

  typedef enum logic [MODE_W-1:0] {
    MODE_MIX       = 3'd0,
    MODE_DUP_ODD   = 3'd1,
    MODE_DUP_EVEN  = 3'd2,
    MODE_KEEP_ODD  = 3'd3,
    MODE_KEEP_EVEN = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             run_last;
    logic             frame_done;
  } res_t;

  // per-byte round-up average of two pixels
  function automatic logic [PIX_W-1:0] avg_up(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    return (a | b) - (((a ^ b) & 32'hfefe_fefe) >> 1);
  endfunction

  // per-byte (a + 2b + c + 2) >> 2 on the three colour bytes, top byte zero
  function automatic logic [PIX_W-1:0] blend3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    hi = (a & 32'h00fc_fcfc) + ((b & 32'h00fc_fcfc) << 1) + (c & 32'h00fc_fcfc);
    lo = (a & 32'h0003_0303) + ((b & 32'h0003_0303) << 1) + (c & 32'h0003_0303)
         + 32'h0002_0202;
    return (hi + (lo & 32'h000c_0c0c)) >> 2;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/deinterlace_line_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deinterlace_line_filter
// Vertical deinterlacer on a raster pixel stream: blend, line doubling and
// field discard, using two line buffers and row/column counters.
// ----------------------------------------------------------------------------
//  port group | role          | payload
//  in_*       | pixel input   | tdata = pixel_in
//  out_*      | pixel result  | tdata = pixel_out, tuser = run_last, tlast = frame_done
//  cfg_*      | apb registers | 0x0 mode, 0x4 frame_width, 0x8 frame_height
//
//  one input item per cycle while the output queue has room for two results;
//  results land in a 4-entry output queue after the input register. the last
//  row of blend/dup modes gives two results per item, so there the input rate
//  follows the 1 result/cycle output port. the line buffers take one read and
//  one write per cycle, with a bypass when both hit the same column. rst_n is
//  synchronous; line buffers are not cleared. in_tready depends only on
//  internal state, never on out_tready in the same cycle.
// ----------------------------------------------------------------------------
module deinterlace_line_filter
  import dlf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [PIX_W-1:0]  in_tdata,     // [31:0] pixel_in
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [PIX_W-1:0]       out_tdata,    // [31:0] pixel_out
  output logic                   out_tuser,    // [0] run_last
  output logic                   out_tlast,    // frame_done
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [3:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  // configuration
  logic [MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MIX;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MODE:   mode_r   <= cfg_pwdata[MODE_W-1:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MODE:   cfg_prdata = {{(32-MODE_W){1'b0}}, mode_r};
      REG_WIDTH:  cfg_prdata = {{(32-DIM_W){1'b0}}, width_r};
      REG_HEIGHT: cfg_prdata = {{(32-DIM_W){1'b0}}, height_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // clamped frame size
  logic [CMP_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [DIM_W-1:0] h_even;

  always_comb begin
    priority if (width_r == '0)
      w_eff = CMP_W'(1);
    else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH))
      w_eff = CMP_W'(MAX_WIDTH);
    else
      w_eff = CMP_W'(width_r);
    priority if (height_r == '0)
      h_eff = DIM_W'(1);
    else if (height_r > DIM_W'(MAX_HEIGHT))
      h_eff = DIM_W'(MAX_HEIGHT);
    else
      h_eff = height_r;
  end

  assign h_even = {h_eff[DIM_W-1:1], 1'b0};

  // counters and input register
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             lc0, lr0;
  logic             accept;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_adv;
  logic [PIX_W-1:0] pin1_r;
  logic [COL_W-1:0] x1_r;
  logic [ROW_W-1:0] r1_r;
  logic             lc1_r, lr1_r;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign lc0 = ({1'b0, CMP_W'(col_r)} + (CMP_W+1)'(1)) >= {1'b0, w_eff};
  assign lr0 = ({1'b0, row_r} + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);

  // room for two results, looking at the queue before this cycle's pop
  assign s1_adv    = s1_valid_r && (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign in_tready = !s1_valid_r || s1_adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (lc0) begin
        col_nxt = '0;
        row_nxt = lr0 ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin1_r <= in_tdata;
      x1_r   <= col_r;
      r1_r   <= row_r;
      lc1_r  <= lc0;
      lr1_r  <= lr0;
    end
  end

  // line buffers: written when the item leaves the input register
  logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
  logic [PIX_W-1:0] bp_mem   [MAX_WIDTH];
  logic [PIX_W-1:0] prev_q, bp_q;
  logic             byp;

  assign byp = s1_adv && (x1_r == col_r);

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      prev_mem[x1_r] <= pin1_r;
      bp_mem[x1_r]   <= prev_q;
    end
    if (accept) begin
      prev_q <= byp ? pin1_r : prev_mem[col_r];
      bp_q   <= byp ? prev_q : bp_mem[col_r];
    end
  end

  // result selection
  logic             a_v, b_v, a_done, b_done;
  logic [PIX_W-1:0] a_pix, b_pix;
  logic [DIM_W-1:0] r_p1, r_p2;

  assign r_p1 = DIM_W'(r1_r) + DIM_W'(1);
  assign r_p2 = DIM_W'(r1_r) + DIM_W'(2);

  always_comb begin
    a_v    = 1'b0;
    b_v    = 1'b0;
    a_done = 1'b0;
    b_done = 1'b0;
    a_pix  = pin1_r;
    b_pix  = pin1_r;
    unique case (mode_r)
      MODE_KEEP_ODD: begin
        a_v    = r1_r[0];
        a_done = lc1_r && (r_p1 >= h_even);
      end
      MODE_KEEP_EVEN: begin
        a_v    = !r1_r[0] && (r_p1 < h_eff);
        a_done = lc1_r && (r_p2 >= h_even);
      end
      default: begin
        // output row r-1 while row r arrives
        a_v = (r1_r != '0);
        priority if (mode_r == MODE_DUP_ODD)
          a_pix = r1_r[0] ? prev_q : bp_q;
        else if (mode_r == MODE_DUP_EVEN)
          a_pix = r1_r[0] ? pin1_r : prev_q;
        else if (r1_r == ROW_W'(1))
          a_pix = avg_up(prev_q, pin1_r);
        else
          a_pix = blend3(bp_q, prev_q, pin1_r);
        // last input row also sends the final output row
        b_v    = lr1_r;
        b_done = lc1_r;
        priority if (r1_r == '0)
          b_pix = pin1_r;
        else if (mode_r == MODE_DUP_ODD)
          b_pix = r1_r[0] ? prev_q : pin1_r;
        else if (mode_r == MODE_DUP_EVEN)
          b_pix = pin1_r;
        else
          b_pix = avg_up(prev_q, pin1_r);
      end
    endcase
  end

  // output queue
  res_t                oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wptr_r, rptr_r;
  logic                pop;
  logic                push_a, push_b;

  assign push_a     = s1_adv && a_v;
  assign push_b     = s1_adv && b_v;
  assign pop        = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = oq_r[rptr_r].pixel;
  assign out_tuser  = oq_r[rptr_r].run_last;
  assign out_tlast  = oq_r[rptr_r].frame_done;

  assign cnt_nxt = cnt_r + OQ_CNT_W'(push_a) + OQ_CNT_W'(push_b) - OQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + OQ_PTR_W'(push_a) + OQ_PTR_W'(push_b);
      rptr_r <= rptr_r + OQ_PTR_W'(pop);
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a)
      oq_r[wptr_r] <= '{pixel: a_pix, run_last: !b_v, frame_done: a_done};
    if (push_b)
      oq_r[wptr_r + OQ_PTR_W'(push_a)] <= '{pixel: b_pix, run_last: 1'b1,
                                            frame_done: b_done};
  end

endmodule
`default_nettype wire

// ===== rtl/dlf_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_checker
// Port-level checks for the deinterlace line filter, bound to the top level.
// ----------------------------------------------------------------------------
module dlf_checker
  import dlf_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [PIX_W-1:0] out_tdata,
  input wire logic             out_tuser,
  input wire logic             out_tlast,
  input wire logic             cfg_pready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // end of frame is always the last result of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("frame_done without run_last");

  // reset empties the queue and opens the input
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind deinterlace_line_filter dlf_checker u_dlf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raster pixel frames through the deinterlace line filter under all five
// modes, odd and even heights, clamped sizes and mid-frame register changes,
// and checks every result item against an in-bench model of the line buffers or a typed-in result.
// ----------------------------------------------------------------------------
module testbench
  import dlf_pkg::*;
;

  localparam int         CYCLE_LIMIT  = 400_000;
  localparam int         SETTLE_TICKS = 8;
  localparam logic [1:0] REG_NONE     = 2'd3;
  localparam logic [2:0] MODE_SPARE   = 3'd7;

  typedef enum logic {ROW_CFG, ROW_PIX} row_op_t;

  typedef struct packed {
    row_op_t     op;
    logic [1:0]  sel;
    logic [31:0] data;
    logic        typed;
    res_t        want;
  } stim_row_t;

  localparam res_t NO_RES = '0;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_tvalid    = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata     = '0;
  logic              out_tvalid;
  logic              out_tready   = 1'b0;
  logic [PIX_W-1:0]  out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_psel     = 1'b0;
  logic              cfg_penable  = 1'b0;
  logic              cfg_pwrite   = 1'b0;
  logic [3:0]        cfg_paddr    = '0;
  logic [31:0]       cfg_pwdata   = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // tag travelling with the item on the input bus: a typed-in result overrides the model
  logic              item_typed   = 1'b0;
  res_t              item_want    = '0;

  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                pixels_sent    = 0;
  int                fail_count     = 0;
  int                cycle_count    = 0;

  // model state
  logic [31:0]       row_above     [MAX_WIDTH];
  logic [31:0]       row_two_above [MAX_WIDTH];
  logic [12:0]       col_cnt    = '0;
  logic [11:0]       row_cnt    = '0;
  logic [2:0]        mode_reg   = MODE_MIX;
  logic [12:0]       width_reg  = 13'd720;
  logic [12:0]       height_reg = 13'd480;

  res_t              pending_pixels [$];

  stim_row_t directed_rows [0:41] = '{
    '{ROW_CFG, REG_WIDTH,  32'd2,          1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd1,          1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_MIX,       1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hffff_ffff,  1'b1, '{32'hffff_ffff, 1'b1, 1'b0}},
    '{ROW_PIX, REG_NONE,   32'h0000_0000,  1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
    '{ROW_CFG, REG_MODE,   MODE_KEEP_ODD,  1'b0, NO_RES},
    '{ROW_CFG, REG_WIDTH,  32'd1,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'ha5a5_a5a5,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_MIX,       1'b0, NO_RES},
    '{ROW_CFG, REG_WIDTH,  32'd2,          1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd3,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hffff_ffff,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h0000_0000,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h0101_0101,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hfefe_fefe,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h8080_8080,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h7f7f_7f7f,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_DUP_ODD,   1'b0, NO_RES},
    '{ROW_CFG, REG_WIDTH,  32'd1,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h1122_3344,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h5566_7788,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h99aa_bbcc,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_DUP_EVEN,  1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd4,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h0000_0000,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hffff_ffff,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h0f0f_0f0f,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hf0f0_f0f0,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_KEEP_EVEN, 1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd3,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h3c3c_3c3c,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hc3c3_c3c3,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h5a5a_5a5a,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_SPARE,     1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd2,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'hfe01_fe01,  1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h01fe_01fe,  1'b0, NO_RES},
    '{ROW_CFG, REG_NONE,   32'hffff_ffff,  1'b0, NO_RES},
    '{ROW_CFG, REG_MODE,   MODE_MIX,       1'b0, NO_RES},
    '{ROW_CFG, REG_WIDTH,  32'h0000_2000,  1'b0, NO_RES},
    '{ROW_CFG, REG_HEIGHT, 32'd0,          1'b0, NO_RES},
    '{ROW_PIX, REG_NONE,   32'h1234_5678,  1'b1, '{32'h1234_5678, 1'b1, 1'b1}}
  };

  deinterlace_line_filter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [31:0] pixel_in
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),     // [31:0] pixel_out
    .out_tuser   (out_tuser),     // [0] run_last
    .out_tlast   (out_tlast),     // frame_done
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  // per-byte rounded-up mean of two pixels, all four bytes
  function automatic logic [31:0] mean2(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    logic [8:0]  s;
    for (int i = 0; i < 4; i++) begin
      s = a[8*i +: 8] + b[8*i +: 8] + 9'd1;
      r[8*i +: 8] = s[8:1];
    end
    return r;
  endfunction

  // 1-2-1 vertical tap on the colour bytes, top byte cleared
  function automatic logic [31:0] mean121(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    logic [31:0] r;
    logic [9:0]  s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      s = a[8*i +: 8] + (b[8*i +: 8] << 1) + c[8*i +: 8] + 10'd2;
      r[8*i +: 8] = s[9:2];
    end
    return r;
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] sel);
    case (sel)
      REG_MODE:  return {29'd0, mode_reg};
      REG_WIDTH: return {19'd0, width_reg};
      default:   return {19'd0, height_reg};
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // one pixel through the line buffers; gives up to two result items
  task automatic filter_pixel(input logic [31:0] pin, output res_t res_a,
                              output res_t res_b, output int n);
    int unsigned w, h, r, o, half;
    logic [11:0] x;
    logic [31:0] above, two_above, v;
    logic        last_col, last_row;
    res_t        found [2];
    w         = clamp_dim(width_reg);
    h         = clamp_dim(height_reg);
    x         = col_cnt[11:0];
    r         = row_cnt;
    last_col  = (col_cnt + 1 >= w);
    last_row  = (r + 1 >= h);
    above     = row_above[x];
    two_above = row_two_above[x];
    half      = h >> 1;
    n         = 0;
    found[0]  = '0;
    found[1]  = '0;
    case (mode_reg)
      MODE_KEEP_ODD: begin
        if (r[0]) begin
          found[n] = '{pin, 1'b0, last_col && (r + 1 >= 2 * half)};
          n++;
        end
      end
      MODE_KEEP_EVEN: begin
        if (!r[0] && r + 1 < h) begin
          found[n] = '{pin, 1'b0, last_col && (r + 2 >= 2 * half)};
          n++;
        end
      end
      default: begin
        // output row r-1 leaves while row r comes in
        if (r >= 1) begin
          o = r - 1;
          if (mode_reg == MODE_DUP_ODD) v = o[0] ? two_above : above;
          else if (mode_reg == MODE_DUP_EVEN) v = o[0] ? above : pin;
          else v = (o == 0) ? mean2(above, pin) : mean121(two_above, above, pin);
          found[n] = '{v, 1'b0, 1'b0};
          n++;
        end
        if (last_row) begin
          if (r == 0) v = pin;
          else if (mode_reg == MODE_DUP_ODD) v = r[0] ? above : pin;
          else if (mode_reg == MODE_DUP_EVEN) v = pin;
          else v = mean2(above, pin);
          found[n] = '{v, 1'b0, last_col};
          n++;
        end
      end
    endcase
    if (n > 0) found[n-1].run_last = 1'b1;
    row_two_above[x] = above;
    row_above[x]     = pin;
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? 12'd0 : row_cnt + 12'd1;
    end else begin
      col_cnt = col_cnt + 13'd1;
    end
    res_a = found[0];
    res_b = found[1];
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    res_t want, res_a, res_b;
    int   n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_pixels.size() == 0) begin
          $error("pixel_out: item %h arrived with nothing outstanding", out_tdata);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          check_field("pixel_out", want.pixel, out_tdata);
          check_field("run_last", want.run_last, out_tuser);
          check_field("frame_done", want.frame_done, out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        filter_pixel(in_tdata, res_a, res_b, n);
        if (item_typed) begin
          pending_pixels.push_back(item_want);
        end else begin
          if (n > 0) pending_pixels.push_back(res_a);
          if (n > 1) pending_pixels.push_back(res_b);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_MODE:   mode_reg   = cfg_pwdata[2:0];
          REG_WIDTH:  width_reg  = cfg_pwdata[12:0];
          REG_HEIGHT: height_reg = cfg_pwdata[12:0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** deinterlace_line_filter: FAILED **");
      $finish;
    end
  end

  task automatic reg_access(input logic wr, input logic [1:0] sel,
                            input logic [31:0] wdata, input logic [31:0] want);
    string name;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (!wr) begin
      case (sel)
        REG_MODE:  name = "mode";
        REG_WIDTH: name = "frame_width";
        default:   name = "frame_height";
      endcase
      check_field(name, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_pixel(input logic [31:0] pix, input logic typed, input res_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= pix;
    item_typed <= typed;
    item_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // sender holds off until every outstanding result is out, then lets the pipe settle
  task automatic wait_for_quiet();
    in_tvalid <= 1'b0;
    // let the last accepted item reach the model queue first
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic random_frame();
    logic [2:0]  m;
    logic [12:0] w, h;
    logic [31:0] junk;
    int          wf, hf, k, left;
    logic        cut;
    m    = 3'($urandom_range(0, 7));
    w    = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(7, 40))
                                       : 13'($urandom_range(0, 6));
    cut  = ($urandom_range(0, 4) == 0);
    if (cut && $urandom_range(0, 1)) h = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
    else h = 13'($urandom_range(0, 7));
    junk = $urandom;
    wait_for_quiet();
    reg_access(1'b1, REG_MODE, {junk[31:3], m}, '0);
    reg_access(1'b1, REG_WIDTH, {junk[31:13], w}, '0);
    reg_access(1'b1, REG_HEIGHT, {junk[31:13], h}, '0);
    for (int i = 0; i < 3; i++) reg_access(1'b0, i[1:0], '0, reg_value(i[1:0]));
    wf = clamp_dim(w);
    hf = clamp_dim(h);
    if (cut) begin
      // stop part-way, move mode and height, then finish whatever row count now says
      k = $urandom_range(1, wf * 4);
      repeat (k) push_pixel($urandom, 1'b0, NO_RES);
      wait_for_quiet();
      junk = $urandom;
      reg_access(1'b1, REG_MODE, junk, '0);
      reg_access(1'b1, REG_HEIGHT, {junk[31:13], 13'($urandom_range(0, 6))}, '0);
      hf = clamp_dim(height_reg);
      if (col_cnt == 0 && row_cnt == 0) left = 0;
      else if (row_cnt + 1 >= hf) left = wf - col_cnt;
      else left = (hf - 1 - row_cnt) * wf + (wf - col_cnt);
      repeat (left) push_pixel($urandom, 1'b0, NO_RES);
    end else begin
      repeat (wf * hf) push_pixel($urandom, 1'b0, NO_RES);
    end
  endtask

  initial begin
    int start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_access(1'b0, REG_MODE, '0, 32'd0);
    reg_access(1'b0, REG_WIDTH, '0, 32'd720);
    reg_access(1'b0, REG_HEIGHT, '0, 32'd480);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        wait_for_quiet();
        reg_access(1'b1, directed_rows[i].sel, directed_rows[i].data, '0);
      end else begin
        push_pixel(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 0) begin
        // wide single rows at the width limit and clamped from above it,
        // cut short by a width write that makes the next pixel the last column
        for (int i = 0; i < 2; i++) begin
          wait_for_quiet();
          reg_access(1'b1, REG_MODE, (i == 0) ? MODE_DUP_ODD : MODE_MIX, '0);
          reg_access(1'b1, REG_WIDTH, (i == 0) ? 32'd4096 : 32'd8191, '0);
          reg_access(1'b1, REG_HEIGHT, 32'd1, '0);
          repeat (8) push_pixel($urandom, 1'b0, NO_RES);
          wait_for_quiet();
          reg_access(1'b1, REG_WIDTH, 32'd1, '0);
          push_pixel($urandom, 1'b0, NO_RES);
        end
      end
      start = pixels_sent;
      while (pixels_sent - start < 150) random_frame();
    end

    wait_for_quiet();
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("** deinterlace_line_filter: PASSED **");
    end else begin
      $display("** deinterlace_line_filter: FAILED **");
    end
    $finish;
  end

endmodule
